@@ src/mrrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrrb_pkg;

  // default sizes
  localparam int unsigned BufLenDef     = 1024;
  localparam int unsigned NumReadersDef = 4;

  // request function codes
  localparam logic [2:0] FN_WRITE = 3'd0;
  localparam logic [2:0] FN_OPEN  = 3'd1;
  localparam logic [2:0] FN_CLOSE = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;
  localparam logic [2:0] FN_CLEAR = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_NUM  = 3'd1;
  localparam logic [2:0] ST_NOT_OPEN = 3'd2;
  localparam logic [2:0] ST_NO_SLOT  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] reader_number;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic [3:0] opened_reader;
    logic [9:0] pending_count;
  } rsp_t;

  // ring store access from the controller
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_ctl_t;

endpackage

`default_nettype wire

@@ src/mrrb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrrb_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  wire                 clk_i,
  input  wire mrrb_pkg::ram_ctl_t ctl_i,
  input  wire  [AddrW-1:0]    addr_i,
  input  wire  [7:0]          wdata_i,
  output logic [7:0]          rdata_o
);
  import mrrb_pkg::*;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // single port byte store, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/mrrb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrrb_ctrl #(
  parameter int unsigned BufLen     = 1024,
  parameter int unsigned NumReaders = 4,
  parameter int unsigned PtrW       = 10
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  wire mrrb_pkg::req_t req_i,
  output mrrb_pkg::ram_ctl_t  ram_ctl_o,
  output logic [PtrW-1:0]     ram_addr_o,
  input  wire  [7:0]          ram_rdata_i,
  output logic                done_o,
  output mrrb_pkg::rsp_t      rsp_o
);
  import mrrb_pkg::*;

  localparam int unsigned SlotW  = (NumReaders > 1) ? $clog2(NumReaders) : 1;
  localparam int unsigned PendW  = $bits(rsp_o.pending_count);
  localparam int unsigned NumW   = $bits(req_i.reader_number);
  localparam int unsigned OpenW  = $bits(rsp_o.opened_reader);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(BufLen - 1);
  localparam logic [PtrW:0]   LenExt  = (PtrW + 1)'(BufLen);

  // pointer state
  logic [PtrW-1:0]       wp_q, wp_d;
  logic [PtrW-1:0]       head_q [NumReaders];
  logic [PtrW-1:0]       head_d [NumReaders];
  logic [NumReaders-1:0] active_q, active_d;

  // result register
  logic             done_q;
  logic [2:0]       status_q, status_d;
  logic             valid_q, valid_d;
  logic [OpenW-1:0] opened_q, opened_d;
  logic [PendW-1:0] pend_q, pend_d;

  logic                  num_ok;
  logic [SlotW-1:0]      slot;
  logic [PtrW-1:0]       cur_head;
  logic [PtrW-1:0]       next_head;
  logic                  free_found;
  logic [SlotW-1:0]      free_idx;
  logic [NumReaders-1:0] others;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == LastPtr) ? '0 : p + PtrW'(1);
    return r;
  endfunction

  // modular distance from head to tail
  function automatic logic [PendW-1:0] distance(input logic [PtrW-1:0] w,
                                                input logic [PtrW-1:0] h);
    logic [PtrW:0] d;
    if (w >= h) begin
      d = {1'b0, w} - {1'b0, h};
    end else begin
      d = {1'b0, w} + LenExt - {1'b0, h};
    end
    return PendW'(d[PtrW-1:0]);
  endfunction

  // reader number decode
  always_comb begin
    num_ok = (req_i.reader_number != '0) &&
             (req_i.reader_number <= NumW'(NumReaders));
    slot     = num_ok ? SlotW'(req_i.reader_number - NumW'(1)) : '0;
    cur_head = head_q[slot];
    next_head = advance(cur_head);
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = NumReaders - 1; j >= 0; j--) begin
      if (!active_q[j]) begin
        free_found = 1'b1;
        free_idx   = SlotW'(j);
      end
    end
  end

  // request decode and next state
  always_comb begin
    wp_d      = wp_q;
    head_d    = head_q;
    active_d  = active_q;
    status_d  = ST_OK;
    valid_d   = 1'b0;
    opened_d  = '0;
    pend_d    = '0;
    others    = active_q;
    others[slot] = 1'b0;
    ram_ctl_o  = '0;
    ram_addr_o = cur_head;

    case (req_i.func)
      FN_OPEN: begin
        if (!free_found) begin
          status_d = ST_NO_SLOT;
        end else begin
          wp_d               = (active_q == '0) ? '0 : wp_q;
          head_d[free_idx]   = wp_d;
          active_d[free_idx] = 1'b1;
          opened_d           = OpenW'(free_idx) + OpenW'(1);
        end
      end
      FN_WRITE: begin
        ram_ctl_o.wr_en = accept_i;
        ram_addr_o      = wp_q;
        wp_d            = advance(wp_q);
        if (num_ok && active_q[slot]) begin
          pend_d = distance(wp_d, cur_head);
        end
      end
      FN_CLOSE, FN_READ, FN_CLEAR: begin
        if (!num_ok) begin
          status_d = ST_BAD_NUM;
        end else if (!active_q[slot]) begin
          status_d = ST_NOT_OPEN;
        end else begin
          case (req_i.func)
            FN_CLOSE: begin
              active_d[slot] = 1'b0;
              head_d[slot]   = '0;
              if (others == '0) begin
                wp_d = '0;
              end
            end
            FN_READ: begin
              if (cur_head == wp_q) begin
                status_d = ST_EMPTY;
              end else begin
                ram_ctl_o.rd_en = accept_i;
                valid_d         = 1'b1;
                head_d[slot]    = next_head;
                pend_d          = distance(wp_q, next_head);
              end
            end
            default: begin
              head_d[slot] = wp_q;
            end
          endcase
        end
      end
      default: begin
        if (num_ok && active_q[slot]) begin
          pend_d = distance(wp_q, cur_head);
        end
      end
    endcase
  end

  // pointer and slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      active_q <= '0;
      done_q   <= 1'b0;
      for (int i = 0; i < NumReaders; i++) begin
        head_q[i] <= '0;
      end
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        wp_q     <= wp_d;
        active_q <= active_d;
        head_q   <= head_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q <= status_d;
      valid_q  <= valid_d;
      opened_q <= opened_d;
      pend_q   <= pend_d;
    end
  end

  // read byte comes straight from the store's output register
  always_comb begin
    rsp_o.status        = status_q;
    rsp_o.read_byte     = valid_q ? ram_rdata_i : '0;
    rsp_o.byte_valid    = valid_q;
    rsp_o.opened_reader = opened_q;
    rsp_o.pending_count = pend_q;
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

@@ src/multi_reader_ring_buffer_top.sv @@
// Multi-reader broadcast receive ring.
// One byte ring is shared by several reader slots; writes append at a single
// tail, and every open reader walks its own head behind it.
// Request channel: drive req_i with start high; the request is taken at a
// rising edge where start is high and busy is low. busy stays low, so a
// request can be taken on every cycle.
// Result channel: done_o is high for exactly one cycle per taken request, in
// the cycle after it was taken, with rsp_o valid in that cycle. The receiver
// cannot stall; it must take the result in that cycle.
// Throughput is one request per cycle: all decode and pointer arithmetic
// sits between the request edge and the result register, and a read fetches
// its byte from the single port ring store, whose registered output feeds
// rsp_o directly.
// Reset clears the tail, all reader heads and all slot flags. The ring store
// itself is not cleared; its entries only become visible once written.
// Overrun of a reader by the tail is not detected: the pending count wraps
// modulo the ring length.
`timescale 1ns / 1ps
`default_nettype none

module multi_reader_ring_buffer_top #(
  parameter int unsigned BufLen     = mrrb_pkg::BufLenDef,
  parameter int unsigned NumReaders = mrrb_pkg::NumReadersDef
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start,
  output logic            busy,
  input  wire mrrb_pkg::req_t req_i,
  output logic            done_o,
  output mrrb_pkg::rsp_t  rsp_o
);
  import mrrb_pkg::*;

  localparam int unsigned PtrW = (BufLen > 1) ? $clog2(BufLen) : 1;

  logic            accept;
  ram_ctl_t        ram_ctl;
  logic [PtrW-1:0] ram_addr;
  logic [7:0]      ram_rdata;

  // never held off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  mrrb_ctrl #(
    .BufLen     (BufLen),
    .NumReaders (NumReaders),
    .PtrW       (PtrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .ram_ctl_o   (ram_ctl),
    .ram_addr_o  (ram_addr),
    .ram_rdata_i (ram_rdata),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  mrrb_ram #(
    .Depth (BufLen),
    .AddrW (PtrW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .wdata_i (req_i.data_byte),
    .rdata_o (ram_rdata)
  );

  // every taken request gives exactly one result in the cycle after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result missing after request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept))
    else $error("result without request");

  // a byte is only delivered by a successful read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.byte_valid) |-> (rsp_o.status == ST_OK))
    else $error("byte delivered with failing status");

  // a freshly opened reader starts at the tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.opened_reader != '0)) |-> (rsp_o.pending_count == '0))
    else $error("opened reader has pending bytes");

  // the ring store is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_ctl.wr_en && ram_ctl.rd_en))
    else $error("ring store write and read collide");

endmodule

`default_nettype wire
